// ----- hw/rtl/cot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cot_pkg: shared types and constants of the circle overlap table
// Request and response formats, table sizing, action codes and FSM states.
// ----------------------------------------------------------------------------
package cot_pkg;

  // Table depth and the widths that follow from it
  localparam int MAX_CIRCLES = 1024;
  localparam int IDX_W       = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CNT_W       = $clog2(MAX_CIRCLES + 1);

  // Field widths
  localparam int COORD_W = 20;
  localparam int RAD_W   = 16;
  localparam int TYPE_W  = 3;
  localparam int MASK_W  = 8;
  localparam int CLR_W   = 16;

  // Datapath widths: center difference, separation and their squares
  localparam int DIFF_W = COORD_W + 1;
  localparam int SEP_W  = RAD_W + 2;
  localparam int DSQ_W  = 2 * DIFF_W - 1;
  localparam int SSQ_W  = 2 * SEP_W;
  localparam int DIST_W = DSQ_W + 1;

  // Action codes
  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_QUERY = 1'b1
  } cot_action_e;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } cot_state_e;

  // One request
  typedef struct packed {
    cot_action_e               action;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic        [RAD_W-1:0]   radius;
    logic        [TYPE_W-1:0]  entry_type;
    logic        [MASK_W-1:0]  type_mask;
    logic signed [CLR_W-1:0]   extra_clearance;
  } cot_req_t;

  // One response
  typedef struct packed {
    logic overlaps;
    logic status;
  } cot_rsp_t;

  // One stored circle
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [RAD_W-1:0]   radius;
    logic        [TYPE_W-1:0]  entry_type;
  } cot_circle_t;

endpackage

// ----- hw/rtl/circle_overlap_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_overlap_table_top: table of circles with an overlap query
// Adds store circles in a synchronous RAM; a query scans the stored entries.
// ----------------------------------------------------------------------------
// An add request writes the circle into the next free slot (status 1 and no
// write when the table holds MAX_CIRCLES circles) and goes straight to the
// response state. A query request reads the N stored circles (none on an
// empty table): the circle RAM has one read port and is read one entry per
// cycle, followed by a three-stage difference / square / compare pipeline
// that must drain before the answer is known. One request is in flight at a
// time; the next one is accepted as soon as the previous response sits in the
// output register, even while that response is stalled.
// No reset sweep is needed: only entries below the fill count are ever read.
module circle_overlap_table_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  cot_pkg::cot_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_stall_i,
  output cot_pkg::cot_rsp_t rsp_o
);
  import cot_pkg::*;

  cot_state_e  state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] iss_q;
  cot_req_t    req_q;
  cot_rsp_t    res_q;
  cot_rsp_t    out_q;
  logic        out_valid_q;
  logic        hit_q;

  // scan pipeline
  cot_circle_t mem_q [MAX_CIRCLES];
  cot_circle_t rd_q;
  logic        v0_q, v1_q, v2_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic [SEP_W-1:0]  sep_q;
  logic              sel1_q, sel2_q;
  logic [DSQ_W-1:0]  dx2_q, dy2_q;
  logic [SSQ_W-1:0]  sep2_q;

  logic        accept, is_add, full, wr_en, issue, scan_done, out_free, hit3;
  cot_circle_t wr_entry;
  logic signed [DIFF_W-1:0]   dx_d, dy_d;
  logic [CLR_W-2:0]           clr_c;
  logic [SEP_W-1:0]           sep_d;
  logic signed [2*DIFF_W-1:0] dx_p, dy_p;
  logic [SSQ_W-1:0]           sep_p;
  logic [DIST_W-1:0]          dist_sq;

  // Handshake and control decodes
  assign req_stall_o = (state_q != ST_IDLE);
  assign accept      = req_valid_i && (state_q == ST_IDLE);
  assign is_add      = (req_i.action == ACT_ADD);
  assign full        = (cnt_q >= CNT_W'(MAX_CIRCLES));
  assign wr_en       = accept && is_add && !full;
  assign issue       = (state_q == ST_SCAN) && (iss_q < cnt_q);
  assign scan_done   = (state_q == ST_SCAN) && !issue && !v0_q && !v1_q && !v2_q;
  assign out_free    = !out_valid_q || !rsp_stall_i;

  assign wr_entry.x          = req_i.center_x;
  assign wr_entry.y          = req_i.center_y;
  assign wr_entry.radius     = req_i.radius;
  assign wr_entry.entry_type = req_i.entry_type;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = is_add ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      iss_q       <= '0;
      hit_q       <= 1'b0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (accept) begin
        iss_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (issue) begin
          iss_q <= iss_q + CNT_W'(1);
        end
        if (hit3) begin
          hit_q <= 1'b1;
        end
      end
      v0_q <= issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      if ((state_q == ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, pending result and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q          <= req_i;
      res_q.overlaps <= 1'b0;
      res_q.status   <= is_add && full;
    end else if (scan_done) begin
      res_q.overlaps <= hit_q;
      res_q.status   <= 1'b0;
    end
    if ((state_q == ST_RESP) && out_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  // Circle RAM: one write, one registered read. Writes happen only in idle
  // and reads only during a scan, so the two never meet on one entry.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IDX_W-1:0]] <= wr_entry;
    end
    if (issue) begin
      rd_q <= mem_q[iss_q[IDX_W-1:0]];
    end
  end

  // Stage 1: center differences, separation, type select
  assign dx_d  = DIFF_W'(req_q.center_x) - DIFF_W'(rd_q.x);
  assign dy_d  = DIFF_W'(req_q.center_y) - DIFF_W'(rd_q.y);
  assign clr_c = req_q.extra_clearance[CLR_W-1] ? '0 : req_q.extra_clearance[CLR_W-2:0];
  assign sep_d = SEP_W'(req_q.radius) + SEP_W'(rd_q.radius) + SEP_W'(clr_c);

  // Stage 2: squares
  assign dx_p  = dx_q * dx_q;
  assign dy_p  = dy_q * dy_q;
  assign sep_p = sep_q * sep_q;

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sep_q  <= sep_d;
    sel1_q <= req_q.type_mask[rd_q.entry_type];
    dx2_q  <= dx_p[DSQ_W-1:0];
    dy2_q  <= dy_p[DSQ_W-1:0];
    sep2_q <= sep_p;
    sel2_q <= sel1_q;
  end

  // Stage 3: squared distance against squared separation, strictly below
  assign dist_sq = DIST_W'(dx2_q) + DIST_W'(dy2_q);
  assign hit3    = v2_q && sel2_q && (dist_sq < DIST_W'(sep2_q));

endmodule

// ----- hw/rtl/cot_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cot_checker: port-level checks for the circle overlap table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module cot_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_stall_o,
  input cot_pkg::cot_req_t req_i,
  input logic              rsp_valid_o,
  input logic              rsp_stall_i,
  input cot_pkg::cot_rsp_t rsp_o
);
  import cot_pkg::*;

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled response changed");

  // Only one request in flight: the cycle after an accept the block stalls
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o)
    else $error("request accepted while another is in flight");

  // A response never reports both a hit and a dropped add
  a_rsp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.overlaps && rsp_o.status))
    else $error("response reports overlap and full together");

  // An accepted request gets no response in the very next cycle from itself:
  // a fresh response only appears after the block has reached its response state
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o && !rsp_valid_o |=> !rsp_valid_o)
    else $error("response appeared in the cycle after acceptance");

endmodule

bind circle_overlap_table_top cot_checker u_cot_checker (.*);

// ----- tb/circle_overlap_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_overlap_table_top_tb: self-checking bench for the circle overlap table
// Sends add and query requests through the valid/stall channels. A shadow
// table and a full scan predict each response that is not typed in, and every
// response is checked field by field. Random idling on both sides, a long
// response hold-off and a fill to capacity are part of the run.
// ----------------------------------------------------------------------------
module circle_overlap_table_top_tb;
  import cot_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int RANDOM_PER_PHASE = 145;
  localparam int HOLDOFF_CYCLES   = 400;
  localparam int DRAIN_CYCLES     = 16;
  localparam int MAX_SHOWN        = 10;
  localparam int TAIL_REQUESTS    = 24;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // One directed request, with the response typed in where it is obvious
  typedef struct {
    cot_req_t request;
    bit       known;
    cot_rsp_t rsp;
  } stim_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     req_valid_i;
  logic     req_stall_o;
  cot_req_t req_i;
  logic     rsp_valid_o;
  logic     rsp_stall_i;
  cot_rsp_t rsp_o;

  // Shadow copy of the circle table
  cot_circle_t shadow_circles [MAX_CIRCLES];
  int unsigned shadow_count = 0;

  cot_rsp_t    pending_rsp [$];
  stim_row_t   directed_rows [$];
  int          error_count  = 0;
  int unsigned cycle_count  = 0;
  idle_mode_e  idle_mode    = IDLE_NONE;
  bit          holdoff_go   = 1'b0;
  int          holdoff_left = 0;

  circle_overlap_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Cycle count and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses pending", cycle_count,
               pending_rsp.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int sender_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 80;
      IDLE_BOTH: return 6;
      default:   return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_mode)
      IDLE_RECV: return 80;
      IDLE_BOTH: return 6;
      default:   return 0;
    endcase
  endfunction

  // Applies one request to the shadow table and returns its response.
  // Overlap: squared center distance strictly below (r1 + r2 + clearance)^2.
  function automatic cot_rsp_t overlap_scan(cot_req_t request);
    cot_rsp_t    rsp;
    cot_circle_t c;
    longint      clr;
    longint      sep;
    longint      dx;
    longint      dy;
    int unsigned i;
    rsp = '0;
    if (request.action == ACT_ADD) begin
      if (shadow_count >= MAX_CIRCLES) begin
        rsp.status = 1'b1;
      end else begin
        c.x          = request.center_x;
        c.y          = request.center_y;
        c.radius     = request.radius;
        c.entry_type = request.entry_type;
        shadow_circles[shadow_count] = c;
        shadow_count++;
      end
    end else begin
      clr = longint'($signed(request.extra_clearance));
      if (clr < 0) clr = 0;
      for (i = 0; i < shadow_count; i++) begin
        c = shadow_circles[i];
        if (request.type_mask[c.entry_type]) begin
          sep = longint'(request.radius) + longint'(c.radius) + clr;
          dx  = longint'($signed(request.center_x)) - longint'($signed(c.x));
          dy  = longint'($signed(request.center_y)) - longint'($signed(c.y));
          if (dx * dx + dy * dy < sep * sep) rsp.overlaps = 1'b1;
        end
      end
    end
    return rsp;
  endfunction

  function automatic stim_row_t directed_row(cot_action_e act, int x, int y, int rad, int typ,
                                             int mask, int clr, bit known, bit ovl, bit st);
    stim_row_t row;
    row.request.action          = act;
    row.request.center_x        = COORD_W'(x);
    row.request.center_y        = COORD_W'(y);
    row.request.radius          = RAD_W'(rad);
    row.request.entry_type      = TYPE_W'(typ);
    row.request.type_mask       = MASK_W'(mask);
    row.request.extra_clearance = CLR_W'(clr);
    row.known                   = known;
    row.rsp.overlaps            = ovl;
    row.rsp.status              = st;
    return row;
  endfunction

  // Random request: full-range noise, a dense cluster near the origin, or a
  // query placed right next to a stored circle to probe the boundary.
  function automatic cot_req_t random_request(int add_pct);
    cot_req_t    request;
    cot_circle_t c;
    logic [95:0] bits;
    int          shape;
    bits    = {$urandom, $urandom, $urandom};
    request = cot_req_t'(bits[$bits(cot_req_t)-1:0]);
    request.action = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_QUERY;
    shape = $urandom_range(9);
    if (shape >= 8 && request.action == ACT_QUERY && shadow_count > 0) begin
      c = shadow_circles[$urandom_range(shadow_count - 1)];
      request.center_x = COORD_W'(int'($signed(c.x)) + int'($urandom_range(200)) - 100);
      request.center_y = COORD_W'(int'($signed(c.y)) + int'($urandom_range(200)) - 100);
      request.radius   = RAD_W'($urandom_range(120));
      request.extra_clearance = CLR_W'(int'($urandom_range(60)) - 20);
      if ($urandom_range(1)) request.type_mask[c.entry_type] = 1'b1;
    end else if (shape >= 3) begin
      request.center_x = COORD_W'(int'($urandom_range(16383)) - 8192);
      request.center_y = COORD_W'(int'($urandom_range(16383)) - 8192);
      request.radius   = RAD_W'($urandom_range(600));
      if ($urandom_range(3) != 0)
        request.extra_clearance = CLR_W'(int'($urandom_range(400)) - 100);
    end
    return request;
  endfunction

  // Drive one request at the falling edge, hold it until accepted, then
  // record the response it must produce.
  task automatic issue_request(input cot_req_t request, input bit known,
                               input cot_rsp_t typed_rsp);
    cot_rsp_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct()) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= request;
    do @(posedge clk_i); while (req_stall_o !== 1'b0);
    predicted = overlap_scan(request);
    pending_rsp.push_back(known ? typed_rsp : predicted);
  endtask

  // Stop sending and wait until every response is back
  task automatic drain_responses();
    @(negedge clk_i);
    req_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Response side stall: random per idle mode, or a long hold-off on demand
  always @(negedge clk_i) begin
    if (holdoff_go) begin
      holdoff_go   = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      rsp_stall_i <= 1'b1;
    end else begin
      rsp_stall_i <= ($urandom_range(99) < receiver_stall_pct());
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    cot_rsp_t want;
    if (rst_ni && rsp_valid_o === 1'b1 && rsp_stall_i == 1'b0) begin
      if (pending_rsp.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("%0t: response %b/%b with no request pending", $realtime,
                   rsp_o.overlaps, rsp_o.status);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.overlaps !== want.overlaps || rsp_o.status !== want.status) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("%0t: overlaps exp %b got %b, status exp %b got %b", $realtime,
                     want.overlaps, rsp_o.overlaps, want.status, rsp_o.status);
        end
      end
    end
  end

  // Stimulus
  initial begin
    cot_rsp_t no_rsp;
    int       n;
    int       phase;
    no_rsp      = '0;
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    rsp_stall_i = 1'b0;

    // Directed rows: empty table, zero radii, strict boundary, masks, extremes
    directed_rows.push_back(directed_row(ACT_QUERY, 0, 0, 65535, 0, 8'hFF, 32767, 1, 0, 0));
    directed_rows.push_back(directed_row(ACT_ADD, 0, 0, 0, 0, 8'h00, 0, 1, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 0, 0, 0, 0, 8'h01, 0, 1, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 0, 0, 0, 0, 8'h01, -32768, 1, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 0, 0, 1, 0, 8'h01, 0, 1, 1, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 0, 0, 0, 0, 8'h01, 1, 1, 1, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 0, 0, 65535, 0, 8'h00, 32767, 1, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 0, 0, 65535, 0, 8'hFE, 32767, 1, 0, 0));
    directed_rows.push_back(directed_row(ACT_ADD, -524288, 524287, 65535, 7, 0, 0, 1, 0, 0));
    directed_rows.push_back(directed_row(ACT_ADD, 524287, -524288, 0, 3, 0, 0, 1, 0, 0));
    directed_rows.push_back(directed_row(ACT_ADD, 1000, -1000, 100, 5, 0, 0, 1, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 524287, 524287, 65535, 0, 8'h80, 32767,
                                         0, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, -524288, -524288, 65535, 0, 8'hFF, 32767,
                                         0, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, -400000, 524287, 30000, 0, 8'h80, -1,
                                         0, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 524287, -524288, 0, 0, 8'h08, 0, 0, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 524287, -524287, 1, 0, 8'h08, 0, 0, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 1100, -1000, 0, 0, 8'h20, 0, 0, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 1100, -1000, 1, 0, 8'h20, 0, 0, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 1100, -1000, 0, 0, 8'h20, 1, 0, 0, 0));
    // add ignores mask and clearance
    directed_rows.push_back(directed_row(ACT_ADD, -1, -1, 16'hAAAA, 2, 8'hFF, -1, 1, 0, 0));
    // query ignores entry type
    directed_rows.push_back(directed_row(ACT_QUERY, -1, -1, 16'h5555, 7, 8'h04, 32767,
                                         0, 0, 0));
    directed_rows.push_back(directed_row(ACT_QUERY, 0, 0, 65535, 0, 8'hFF, 32767, 0, 0, 0));

    // Reset, released at a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].request, directed_rows[i].known, directed_rows[i].rsp);
    drain_responses();

    // Random phases, one per idle mode; the first one also holds off responses
    for (phase = 0; phase < 4; phase++) begin
      idle_mode = idle_mode_e'(phase);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 0 && n == 40) holdoff_go = 1'b1;
        issue_request(random_request(45), 1'b0, no_rsp);
      end
      drain_responses();
    end

    // Fill the table to capacity, then mix dropped adds with full scans
    idle_mode = IDLE_NONE;
    while (shadow_count < MAX_CIRCLES) issue_request(random_request(100), 1'b0, no_rsp);
    idle_mode = IDLE_BOTH;
    for (n = 0; n < TAIL_REQUESTS; n++) issue_request(random_request(50), 1'b0, no_rsp);
    drain_responses();

    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
